@@ hw/rtl/smau_pkg.sv @@
`timescale 1ns / 1ps

package smau_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int WORD_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int OP_W        = 3;
    localparam int ST_W        = 2;
    localparam int STEP_W      = $clog2(WORD_W);
    localparam int OUT_DATA_W  = ((WORD_W + CNT_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd4;
    localparam logic [OP_W-1:0] OP_MOD  = 3'd5;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_SHORT   = 2'd1;
    localparam logic [ST_W-1:0] ST_DIVZERO = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic            load;
        logic            push;
        logic            cap_a;
        logic            calc;
        logic            div_init;
        logic            div_step;
        logic            wb;
        logic            out_load;
        logic [ST_W-1:0] status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            short_stack;
        logic            full;
        logic            b_zero;
        logic            div_last;
    } t_sts;

endpackage

@@ hw/rtl/smau_ram.sv @@
`timescale 1ns / 1ps

module smau_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/smau_datapath.sv @@
`timescale 1ns / 1ps

module smau_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  smau_pkg::t_cmd                         i_cmd,
    output smau_pkg::t_sts                         o_sts,
    input  logic [smau_pkg::OP_W-1:0]              i_op,
    input  logic [smau_pkg::WORD_W-1:0]            i_push_value,
    output logic [smau_pkg::ST_W-1:0]              o_status,
    output logic [smau_pkg::WORD_W-1:0]            o_top_value,
    output logic [smau_pkg::CNT_W-1:0]             o_stack_count
);

    import smau_pkg::*;

    // The top element lives in r_top; the memory holds the elements below it.
    logic [OP_W-1:0]   r_op;
    logic [WORD_W-1:0] r_val;
    logic [CNT_W-1:0]  r_count;
    logic [WORD_W-1:0] r_top;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_res;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_dvs;
    logic [STEP_W-1:0] r_step;
    logic              r_qneg;
    logic              r_rneg;
    logic [ST_W-1:0]   r_o_status;
    logic [WORD_W-1:0] r_o_top;
    logic [CNT_W-1:0]  r_o_count;

    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic [WORD_W-1:0] ram_rdata;
    logic              ram_we;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   diff;
    logic              ge;
    logic [WORD_W-1:0] wb_value;

    assign cnt_m1 = r_count - CNT_W'(1);
    assign cnt_m2 = r_count - CNT_W'(2);
    assign ram_we = i_cmd.push && (r_count != '0);

    smau_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cnt_m1[ADDR_W-1:0]),
        .i_wdata (r_top),
        .i_raddr (cnt_m2[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // One restoring division step on magnitudes.
    assign shifted = {r_rem, r_quo[WORD_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign ge      = shifted >= {1'b0, r_dvs};

    always_comb begin
        case (r_op)
            OP_DIV:  wb_value = r_qneg ? (WORD_W'(0) - r_quo) : r_quo;
            OP_MOD:  wb_value = r_rneg ? (WORD_W'(0) - r_rem) : r_rem;
            default: wb_value = r_res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.wb) begin
            r_count <= cnt_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_val <= i_push_value;
        end
        if (i_cmd.push) begin
            r_top <= r_val;
        end else if (i_cmd.wb) begin
            r_top <= wb_value;
        end
        if (i_cmd.cap_a) begin
            r_a <= ram_rdata;
        end
        if (i_cmd.calc) begin
            case (r_op)
                OP_ADD:  r_res <= r_a + r_top;
                OP_SUB:  r_res <= r_a - r_top;
                default: r_res <= r_a * r_top;
            endcase
        end
        if (i_cmd.div_init) begin
            r_rem  <= '0;
            r_quo  <= r_a[WORD_W-1] ? (WORD_W'(0) - r_a) : r_a;
            r_dvs  <= r_top[WORD_W-1] ? (WORD_W'(0) - r_top) : r_top;
            r_step <= '0;
            r_qneg <= r_a[WORD_W-1] ^ r_top[WORD_W-1];
            r_rneg <= r_a[WORD_W-1];
        end else if (i_cmd.div_step) begin
            r_rem  <= ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
            r_quo  <= {r_quo[WORD_W-2:0], ge};
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.out_load) begin
            r_o_status <= i_cmd.status;
            r_o_top    <= (r_count == '0) ? '0 : r_top;
            r_o_count  <= r_count;
        end
    end

    assign o_sts.op          = r_op;
    assign o_sts.short_stack = r_count < CNT_W'(2);
    assign o_sts.full        = r_count == CNT_W'(STACK_DEPTH);
    assign o_sts.b_zero      = r_top == '0;
    assign o_sts.div_last    = r_step == STEP_W'(WORD_W - 1);

    assign o_status      = r_o_status;
    assign o_top_value   = r_o_top;
    assign o_stack_count = r_o_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count above depth");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> r_count < CNT_W'(STACK_DEPTH))
        else $error("push on a full stack");
    a_wb_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wb |-> r_count >= CNT_W'(2))
        else $error("binary write-back with fewer than two elements");
`endif

endmodule

@@ hw/rtl/smau_ctrl.sv @@
`timescale 1ns / 1ps

module smau_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  smau_pkg::t_sts i_sts,
    output smau_pkg::t_cmd o_cmd
);

    import smau_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_CALC = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_WB   = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]      r_state;
    logic [2:0]      n_state;
    logic [ST_W-1:0] r_status;
    logic [ST_W-1:0] n_status;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            accept;
    logic            out_free;
    logic            is_div;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;
    assign is_div   = (i_sts.op == OP_DIV) || (i_sts.op == OP_MOD);

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_status   = ST_OK;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
                if (i_sts.op == OP_PUSH) begin
                    if (i_sts.full) begin
                        n_status = ST_FULL;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end else if (i_sts.op <= OP_MOD) begin
                    if (i_sts.short_stack) begin
                        n_status = ST_SHORT;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.cap_a = 1'b1;
                n_state     = S_CALC;
            end
            S_CALC: begin
                if (is_div) begin
                    if (i_sts.b_zero) begin
                        n_status = ST_DIVZERO;
                        n_state  = S_OUT;
                    end else begin
                        o_cmd.div_init = 1'b1;
                        n_state        = S_DIV;
                    end
                end else begin
                    o_cmd.calc = 1'b1;
                    n_state    = S_WB;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_EXEC)
        else $error("accepted item did not start execution");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid && r_state == S_IDLE)
        else $error("result load did not raise output valid");
    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.push, o_cmd.wb, o_cmd.div_init, o_cmd.calc}) <= 1)
        else $error("conflicting datapath commands");
`endif

endmodule

@@ hw/rtl/stack_machine_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// From idle, each item passes through execute and result load. Add, sub and mul
// also pass operand read, compute and write-back; div and mod pass operand read,
// compute and, for a nonzero divisor, the 32-step restoring divider and write-back.
// A new item is taken only once the last result is loaded, even while it waits.
// Reset (i_rst_n low, synchronous) empties the stack and drops any pending result;
// stack memory contents are not cleared and need no clearing pass.

module stack_machine_arithmetic_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Instruction stream.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [smau_pkg::WORD_W-1:0]            s_axis_tdata,  // [31:0] push_value
    input  logic [smau_pkg::OP_W-1:0]              s_axis_tuser,  // [2:0] operation
    // Result stream.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [smau_pkg::OUT_DATA_W-1:0]        m_axis_tdata,  // [31:0] top_value,
                                                                  // [38:32] stack_count
    output logic [smau_pkg::ST_W-1:0]              m_axis_tuser   // [1:0] status
);

    import smau_pkg::*;

    t_cmd              cmd;
    t_sts              sts;
    logic [WORD_W-1:0] top_value;
    logic [CNT_W-1:0]  stack_count;

    // The controller sequences each instruction through execute and result load, with
    // operand read, compute, optional divide iterations and write-back for operations.
    smau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath keeps the top of stack in a register and the rest in a RAM,
    // so a binary operation needs only one memory read.
    smau_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (s_axis_tuser),
        .i_push_value  (s_axis_tdata),
        .o_status      (m_axis_tuser),
        .o_top_value   (top_value),
        .o_stack_count (stack_count)
    );

    // Result fields are packed from the lowest bit up and zero-filled to bytes.
    assign m_axis_tdata = {{(OUT_DATA_W - WORD_W - CNT_W){1'b0}}, stack_count, top_value};

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

// Testbench for the stack machine arithmetic unit.
//
// Instructions go in on the slave stream and one result item comes back on the
// master stream for each of them. A scoreboard object keeps its own copy of the
// stack and works out the status, top and count that each accepted instruction
// must give. Results are checked in order against its queue of expected items.

module tb_top;

    import smau_pkg::*;

    // Codes 6 and 7 carry no operation; the block must leave the stack alone.
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic [WORD_W-1:0] INT_MIN_W = 32'h8000_0000;
    localparam logic [WORD_W-1:0] INT_MAX_W = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] MINUS_ONE = 32'hFFFF_FFFF;

    // Least number of real instructions in each random phase, and the length of the long
    // receiver hold-off used to back the block up into its input.
    localparam int PHASE_ITEMS = 312;
    localparam int HOLD_CYCLES = 300;

    // One result item as the block reports it.
    typedef struct {
        logic [ST_W-1:0]   status;
        logic [WORD_W-1:0] top;
        logic [CNT_W-1:0]  count;
    } t_stack_result;

    // Mirror of the stack that predicts each result and checks the real ones.
    class t_stack_scoreboard;
        logic [WORD_W-1:0] words [STACK_DEPTH];
        int unsigned       depth_now;
        t_stack_result     expected_q [$];
        int                errors;

        function new();
            depth_now = 0;
            errors    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string what);
            $display("ERROR at %0t ns: %s", $time, what);
            errors++;
        endtask

        // Apply one accepted instruction to the mirror and queue its result.
        function void note_input(logic [OP_W-1:0] op, logic [WORD_W-1:0] val);
            logic [ST_W-1:0]   st;
            logic [WORD_W-1:0] a;
            logic [WORD_W-1:0] b;
            logic [WORD_W-1:0] r;
            bit                ok;
            t_stack_result     e;
            st = ST_OK;
            ok = 1'b1;
            r  = '0;
            if (op == OP_PUSH) begin
                if (depth_now >= STACK_DEPTH) begin
                    st = ST_FULL;
                end else begin
                    words[depth_now] = val;
                    depth_now++;
                end
            end else if (op <= OP_MOD) begin
                if (depth_now < 2) begin
                    st = ST_SHORT;
                end else begin
                    b = words[depth_now - 1];
                    a = words[depth_now - 2];
                    case (op)
                        OP_ADD: r = a + b;
                        OP_SUB: r = a - b;
                        OP_MUL: r = a * b;
                        default: begin
                            // Div and mod: the overflowing quotient is pinned here,
                            // everything else truncates toward zero.
                            if (b == '0)
                                ok = 1'b0;
                            else if (a == INT_MIN_W && b == MINUS_ONE)
                                r = (op == OP_DIV) ? INT_MIN_W : '0;
                            else if (op == OP_DIV)
                                r = $signed(a) / $signed(b);
                            else
                                r = $signed(a) % $signed(b);
                        end
                    endcase
                    if (ok) begin
                        words[depth_now - 2] = r;
                        depth_now--;
                    end else begin
                        st = ST_DIVZERO;
                    end
                end
            end
            e.status = st;
            e.top    = (depth_now > 0) ? words[depth_now - 1] : '0;
            e.count  = CNT_W'(depth_now);
            expected_q.push_back(e);
        endfunction

        task check_result(logic [ST_W-1:0] st, logic [OUT_DATA_W-1:0] data);
            t_stack_result e;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, data %h", data));
                return;
            end
            e = expected_q.pop_front();
            if (st !== e.status)
                report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
            if (data[WORD_W-1:0] !== e.top)
                report_mismatch($sformatf("top %h, expected %h", data[WORD_W-1:0], e.top));
            if (data[WORD_W +: CNT_W] !== e.count)
                report_mismatch($sformatf("count %0d, expected %0d",
                                          data[WORD_W +: CNT_W], e.count));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [WORD_W-1:0]     s_axis_tdata = '0;    // [31:0] push_value
    logic [OP_W-1:0]       s_axis_tuser = '0;    // [2:0] operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [31:0] top_value, [38:32] stack_count
    logic [ST_W-1:0]       m_axis_tuser;         // [1:0] status

    t_stack_scoreboard sb = new();

    // Idling controls, set by the stimulus process for each phase.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // The stimulus process bumps hold_req to ask for one long hold-off.
    int hold_req = 0;
    int hold_ack = 0;
    int hold_cnt = 0;
    // Instructions that do real work; spare codes are not counted.
    int real_items = 0;

    stack_machine_arithmetic_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Receiver side. A requested hold-off keeps tready low for a counted
    // stretch; otherwise tready stalls at random at the phase's rate.
    always @(posedge i_clk) begin
        if (hold_ack != hold_req) begin
            hold_ack = hold_req;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every accepted result is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);
    end

    // Offer one instruction, with a random gap in front of it, and note it in the
    // scoreboard at the edge where it is taken. The predictor state therefore is
    // up to date before the next instruction is chosen.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] val);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= val;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(op, val);
        if (op <= OP_MOD)
            real_items++;
    endtask

    // Operand values lean on the corners: the extremes, zero, one and minus one.
    function automatic logic [WORD_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)      return INT_MIN_W;
        else if (roll < 20) return INT_MAX_W;
        else if (roll < 30) return '0;
        else if (roll < 40) return MINUS_ONE;
        else if (roll < 50) return 32'd1;
        else if (roll < 75) return WORD_W'($signed($urandom_range(200)) - 100);
        else                return $urandom;
    endfunction

    // Mostly well-formed programs: pushes while the stack is short, then a mix of
    // pushes and binary operations. A few spare codes and operations on a short
    // stack are mixed in as noise.
    task automatic random_item();
        int                roll;
        logic [OP_W-1:0]   op;
        roll = $urandom_range(99);
        if (roll < 4)
            op = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
        else if (roll < 8)
            op = OP_W'($urandom_range(5, 1));
        else if (sb.depth_now < 2 || roll < 50)
            op = OP_PUSH;
        else
            op = OP_W'($urandom_range(5, 1));
        send_item(op, pick_value());
    endtask

    // Push until the stack is full, then push twice more into the full stack.
    task automatic fill_stack();
        while (sb.depth_now < STACK_DEPTH)
            send_item(OP_PUSH, pick_value());
        repeat (2) send_item(OP_PUSH, $urandom);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int phase_end;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed program: short stack, wrap-around, overflowing quotient,
        // zero divisors, spare codes and signed truncation.
        send_item(OP_ADD, 32'h0);
        send_item(OP_PUSH, INT_MAX_W);
        send_item(OP_MOD, 32'h0);
        send_item(OP_PUSH, 32'd1);
        send_item(OP_ADD, MINUS_ONE);
        send_item(OP_PUSH, MINUS_ONE);
        send_item(OP_DIV, 32'h0);
        send_item(OP_PUSH, MINUS_ONE);
        send_item(OP_MOD, 32'h0);
        send_item(OP_PUSH, 32'h0);
        send_item(OP_DIV, 32'h0);
        send_item(OP_MOD, MINUS_ONE);
        send_item(OP_SPARE_6, 32'h0);
        send_item(OP_SPARE_7, MINUS_ONE);
        send_item(OP_PUSH, -32'sd7);
        send_item(OP_PUSH, 32'd2);
        send_item(OP_DIV, 32'h0);
        send_item(OP_PUSH, 32'd2);
        send_item(OP_MOD, 32'h0);
        send_item(OP_PUSH, INT_MIN_W);
        send_item(OP_SUB, 32'h0);
        send_item(OP_PUSH, 32'h0001_0000);
        send_item(OP_PUSH, 32'h0001_0000);
        send_item(OP_MUL, 32'h0);
        send_item(OP_SUB, 32'h0);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // Random phases: free running, idle sender, stalling receiver, both.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            phase_end = real_items + PHASE_ITEMS;
            while (real_items < phase_end) begin
                // The sender keeps offering through the long hold-off, so the
                // block fills up and has to hold its input back.
                if (p == 0 && hold_req == 0 && real_items >= phase_end - PHASE_ITEMS + 100)
                    hold_req++;
                if (real_items % 150 == 75)
                    fill_stack();
                random_item();
            end
            // The sender waits here until every result of the phase is back.
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (60) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Far beyond the slowest correct run.
    initial begin
        #(64'd10_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/smau_pkg.sv
hw/rtl/smau_ram.sv
hw/rtl/smau_datapath.sv
hw/rtl/smau_ctrl.sv
hw/rtl/stack_machine_arithmetic_unit.sv
dv/tb_top.sv
